// ===== hw/rtl/pftb_pkg.sv =====
// Shared types and constants for the per-flow token bucket table.
// No dependencies.
package pftb_pkg;

  localparam logic [2:0] REQ_SET     = 3'd0;
  localparam logic [2:0] REQ_REMOVE  = 3'd1;
  localparam logic [2:0] REQ_CLEAR   = 3'd2;
  localparam logic [2:0] REQ_CONSUME = 3'd3;
  localparam logic [2:0] REQ_QUERY   = 3'd4;

  localparam logic [1:0] DIR_UP   = 2'd0;
  localparam logic [1:0] DIR_DOWN = 2'd1;
  localparam logic [1:0] DIR_BOTH = 2'd2;
  localparam logic [1:0] DIR_NONE = 2'd3;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] process_id;
    logic [1:0]  direction;
    logic [39:0] rate_in;
    logic [31:0] packet_bytes;
    logic [63:0] now_ticks;
  } req_t;

  typedef struct packed {
    logic        status;
    logic        permitted;
    logic        found;
    logic [39:0] rate_out;
    logic [39:0] tokens_out;
  } rsp_t;

endpackage

// ===== hw/rtl/per_flow_token_bucket_table.sv =====
// Per-flow token bucket table: keyed buckets with refill, consume and query.
// Depends on pftb_pkg.
// Consume/query hits scan, read (S_RD, S_RDW), run a 4-step 32x32 multiply and
// a 104-step restoring divide when a refill is due, then update; set scans and
// writes per direction; remove and misses only scan; clear and rejected requests
// go straight to the result. One transaction at a time; ready again in the cycle
// after the result handshake. Reset empties the table; frequency resets to 10000000.
module per_flow_token_bucket_table #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [31:0]     cfg_wdata_i,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  pftb_pkg::req_t  req_i,
  output logic            rsp_valid_o,
  input  logic            rsp_ready_i,
  output pftb_pkg::rsp_t  rsp_o
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_RDW   = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_UPD   = 4'd6;
  localparam logic [3:0] S_SETW  = 4'd7;
  localparam logic [3:0] S_RESP  = 4'd8;

  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [31:0] mem_pid   [TABLE_ENTRIES];
  logic        mem_dir   [TABLE_ENTRIES];
  logic [39:0] mem_rate  [TABLE_ENTRIES];
  logic [39:0] mem_tok   [TABLE_ENTRIES];
  logic [63:0] mem_last  [TABLE_ENTRIES];

  logic [3:0]   state_q;
  logic [31:0]  freq_q;
  pftb_pkg::req_t req_q;
  pftb_pkg::rsp_t rsp_q;
  logic [CW-1:0] idx_q;
  logic [IW-1:0] hit_q, free_q;
  logic          hit_ok_q, free_ok_q;
  logic          cur_dir_q, second_q;
  logic [39:0]   rate_q, tok_q;
  logic [63:0]   last_q, diff_q;
  logic [103:0]  prod_q, quo_q;
  logic [31:0]   rem_q;
  logic [1:0]    mstep_q;
  logic [6:0]    dstep_q;

  logic [IW-1:0] idx_w;
  logic          key_hit;
  assign idx_w   = idx_q[IW-1:0];
  assign key_hit = valid_q[idx_w] && mem_pid[idx_w] == req_q.process_id
                   && mem_dir[idx_w] == cur_dir_q;

  logic [63:0] diff_w;
  assign diff_w = req_q.now_ticks - last_q;

  logic [31:0] ma, mb;
  logic [63:0] mp;
  always_comb begin
    ma = mstep_q[1] ? diff_q[63:32] : diff_q[31:0];
    mb = mstep_q[0] ? {24'd0, rate_q[39:32]} : rate_q[31:0];
    mp = ma * mb;
  end
  logic [6:0] msh;
  assign msh = {1'b0, mstep_q[1], 5'd0} + {1'b0, mstep_q[0], 5'd0};

  logic [32:0] rtry;
  logic [33:0] rsub;
  assign rtry = {rem_q, prod_q[103]};
  assign rsub = {1'b0, rtry} - {2'd0, freq_q};

  logic [39:0] pkt40;
  logic [40:0] tsum;
  logic        big;
  logic [39:0] tok_new;
  assign pkt40 = {8'd0, req_q.packet_bytes};
  assign big   = |quo_q[103:40];
  assign tsum  = {1'b0, tok_q} + {1'b0, quo_q[39:0]};
  assign tok_new = (big || quo_q[39:0] >= rate_q || tsum > {1'b0, rate_q}) ?
                   rate_q : tsum[39:0];

  assign req_ready_o = state_q == S_IDLE;
  assign rsp_valid_o = state_q == S_RESP;
  assign rsp_o       = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      freq_q  <= 32'd10000000;
    end else begin
      if (cfg_we_i) freq_q <= cfg_wdata_i;
      case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            case (req_i.req_type)
              pftb_pkg::REQ_CLEAR: begin
                valid_q <= '0;
                state_q <= S_RESP;
              end
              pftb_pkg::REQ_SET, pftb_pkg::REQ_REMOVE,
              pftb_pkg::REQ_CONSUME, pftb_pkg::REQ_QUERY: begin
                if ((req_i.direction == pftb_pkg::DIR_NONE &&
                     req_i.req_type != pftb_pkg::REQ_REMOVE) ||
                    (req_i.direction == pftb_pkg::DIR_BOTH &&
                     (req_i.req_type == pftb_pkg::REQ_CONSUME ||
                      req_i.req_type == pftb_pkg::REQ_QUERY)))
                  state_q <= S_RESP;
                else
                  state_q <= S_SCAN;
              end
              default: state_q <= S_RESP;
            endcase
          end
        end
        S_SCAN: begin
          if (req_q.req_type == pftb_pkg::REQ_REMOVE) begin
            if (valid_q[idx_w] && mem_pid[idx_w] == req_q.process_id &&
                (req_q.direction == pftb_pkg::DIR_BOTH ||
                 {1'b0, mem_dir[idx_w]} == req_q.direction))
              valid_q[idx_w] <= 1'b0;
          end
          if (idx_q == CW'(TABLE_ENTRIES - 1)) begin
            if (req_q.req_type == pftb_pkg::REQ_REMOVE) state_q <= S_RESP;
            else if (req_q.req_type == pftb_pkg::REQ_SET) state_q <= S_SETW;
            else if (hit_ok_q || key_hit) state_q <= S_RD;
            else state_q <= S_RESP;
          end
        end
        S_SETW: begin
          if (hit_ok_q || free_ok_q) begin
            valid_q[hit_ok_q ? hit_q : free_q] <= 1'b1;
            state_q <= (second_q || req_q.direction != pftb_pkg::DIR_BOTH) ?
                       S_RESP : S_SCAN;
          end else begin
            state_q <= S_RESP;
          end
        end
        S_RD:  state_q <= S_RDW;
        S_RDW: begin
          if (diff_w == '0 || diff_w[63] || rate_q == '0 || freq_q == '0)
            state_q <= S_UPD;
          else
            state_q <= S_MUL;
        end
        S_MUL: if (mstep_q == 2'd3) state_q <= S_DIV;
        S_DIV: if (dstep_q == 7'd103) state_q <= S_UPD;
        S_UPD: state_q <= S_RESP;
        S_RESP: if (rsp_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        req_q     <= req_i;
        rsp_q     <= pftb_pkg::rsp_t'({1'b0, req_i.req_type == pftb_pkg::REQ_CONSUME,
                                        81'd0});
        idx_q     <= '0;
        hit_ok_q  <= 1'b0;
        free_ok_q <= 1'b0;
        second_q  <= 1'b0;
        cur_dir_q <= req_i.direction[0];
      end
      S_SCAN: begin
        if (key_hit && !hit_ok_q) begin
          hit_ok_q <= 1'b1;
          hit_q    <= idx_w;
        end
        if (!valid_q[idx_w] && !free_ok_q) begin
          free_ok_q <= 1'b1;
          free_q    <= idx_w;
        end
        idx_q <= idx_q + CW'(1);
      end
      S_SETW: begin
        if (hit_ok_q || free_ok_q) begin
          mem_pid[hit_ok_q ? hit_q : free_q]  <= req_q.process_id;
          mem_dir[hit_ok_q ? hit_q : free_q]  <= cur_dir_q;
          mem_rate[hit_ok_q ? hit_q : free_q] <= req_q.rate_in;
          mem_tok[hit_ok_q ? hit_q : free_q]  <= req_q.rate_in;
          mem_last[hit_ok_q ? hit_q : free_q] <= req_q.now_ticks;
        end else begin
          rsp_q.status <= 1'b1;
        end
        idx_q     <= '0;
        hit_ok_q  <= 1'b0;
        free_ok_q <= 1'b0;
        second_q  <= 1'b1;
        cur_dir_q <= 1'b1;
      end
      S_RD: begin
        rate_q <= mem_rate[hit_q];
        tok_q  <= mem_tok[hit_q];
        last_q <= mem_last[hit_q];
      end
      S_RDW: begin
        diff_q  <= diff_w;
        prod_q  <= '0;
        mstep_q <= '0;
      end
      S_MUL: begin
        prod_q  <= prod_q + (104'(mp) << msh);
        mstep_q <= mstep_q + 2'd1;
        rem_q   <= '0;
        dstep_q <= '0;
        quo_q   <= '0;
      end
      S_DIV: begin
        prod_q  <= prod_q << 1;
        dstep_q <= dstep_q + 7'd1;
        if (!rsub[33]) begin
          rem_q <= rsub[31:0];
          quo_q <= {quo_q[102:0], 1'b1};
        end else begin
          rem_q <= rtry[31:0];
          quo_q <= {quo_q[102:0], 1'b0};
        end
      end
      S_UPD: begin : upd
        logic [39:0] t;
        logic        add;
        add = !(diff_q == '0 || diff_q[63] || rate_q == '0 || freq_q == '0)
              && (big || quo_q[39:0] != '0);
        t = add ? tok_new : tok_q;
        if (add || diff_q == '0 || diff_q[63] || rate_q == '0 || freq_q == '0)
          mem_last[hit_q] <= req_q.now_ticks;
        if (req_q.req_type == pftb_pkg::REQ_CONSUME) begin
          if (t >= pkt40) mem_tok[hit_q] <= t - pkt40;
          else begin
            mem_tok[hit_q]  <= t;
            rsp_q.permitted <= 1'b0;
          end
        end else begin
          mem_tok[hit_q]   <= t;
          rsp_q.found      <= 1'b1;
          rsp_q.rate_out   <= rate_q;
          rsp_q.tokens_out <= t;
        end
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !req_ready_o) else $error("ready while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.found) |-> rsp_o.tokens_out <= rsp_o.rate_out)
    else $error("tokens above rate");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && !rsp_ready_i) |=> state_q == S_RESP)
    else $error("result dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> dstep_q <= 7'd103) else $error("divider overrun");

endmodule
